// ===== rtl/core/xsr_pkg.sv =====
// xsr_pkg: shared types and constants for the xorshift128 ranged generator.
// No dependencies; used by every module of the core.
package xsr_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned CntW  = 5;

    localparam logic [1:0] OP_RAW    = 2'd0;
    localparam logic [1:0] OP_RANGED = 2'd1;
    localparam logic [1:0] OP_RESEED = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EQUAL   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [WordW-1:0] SEED_X = 32'd123456789;
    localparam logic [WordW-1:0] SEED_Y = 32'd362436069;
    localparam logic [WordW-1:0] SEED_Z = 32'd521288629;
    localparam logic [WordW-1:0] SEED_W = 32'd88675123;

    localparam int unsigned SHIFT_X_L = 11;
    localparam int unsigned SHIFT_T_R = 8;
    localparam int unsigned SHIFT_W_R = 19;

    localparam logic [CntW-1:0] DIV_LAST = 5'(WordW - 1);

    typedef struct packed {
        logic [1:0]              opcode;
        logic signed [WordW-1:0] range_min;
        logic signed [WordW-1:0] range_max;
    } req_t;

    typedef struct packed {
        logic [WordW-1:0]        raw_word;
        logic signed [WordW-1:0] ranged_value;
        logic [1:0]              range_status;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic need_div;
    } sts_t;

endpackage

// ===== rtl/core/xsr_datapath.sv =====
// xsr_datapath: generator state words, result registers and restoring remainder unit.
// Depends on xsr_pkg.
module xsr_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  xsr_pkg::req_t  req,
    input  xsr_pkg::cmd_t  cmd,
    output xsr_pkg::sts_t  sts,
    output xsr_pkg::rsp_t  rsp
);

    logic [xsr_pkg::WordW-1:0] x_reg, y_reg, z_reg, w_reg;
    logic [xsr_pkg::WordW-1:0] x_next, y_next, z_next, w_next;
    logic [xsr_pkg::WordW-1:0] t_val, new_w;

    logic [xsr_pkg::WordW-1:0] raw_reg, lo_reg, rem_reg, dvd_reg;
    logic [xsr_pkg::WordW:0]   span_reg;
    logic [1:0]                status_reg;

    logic                      lo_gt_hi, lo_eq_hi, advancing;
    logic [xsr_pkg::WordW:0]   span_val, shifted;
    logic [xsr_pkg::WordW+1:0] trial;
    logic [1:0]                status_val;

    assign t_val = x_reg ^ (x_reg << xsr_pkg::SHIFT_X_L);
    assign new_w = (w_reg ^ (w_reg >> xsr_pkg::SHIFT_W_R))
                 ^ (t_val ^ (t_val >> xsr_pkg::SHIFT_T_R));

    assign advancing = (req.opcode == xsr_pkg::OP_RAW) || (req.opcode == xsr_pkg::OP_RANGED);
    assign lo_gt_hi  = req.range_min > req.range_max;
    assign lo_eq_hi  = req.range_min == req.range_max;
    assign span_val  = {req.range_max[xsr_pkg::WordW-1], req.range_max}
                     - {req.range_min[xsr_pkg::WordW-1], req.range_min}
                     + {{xsr_pkg::WordW{1'b0}}, 1'b1};

    always_comb
    begin
        status_val = xsr_pkg::ST_OK;
        if (req.opcode == xsr_pkg::OP_RANGED)
        begin
            if (lo_gt_hi)
                status_val = xsr_pkg::ST_INVALID;
            else if (lo_eq_hi)
                status_val = xsr_pkg::ST_EQUAL;
        end
    end

    assign sts.need_div = (req.opcode == xsr_pkg::OP_RANGED) && !lo_gt_hi;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        w_next = w_reg;
        if (cmd.load)
        begin
            if (advancing)
            begin
                x_next = y_reg;
                y_next = z_reg;
                z_next = w_reg;
                w_next = new_w;
            end
            else if (req.opcode == xsr_pkg::OP_RESEED)
            begin
                x_next = xsr_pkg::SEED_X;
                y_next = xsr_pkg::SEED_Y;
                z_next = xsr_pkg::SEED_Z;
                w_next = xsr_pkg::SEED_W;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= xsr_pkg::SEED_X;
            y_reg <= xsr_pkg::SEED_Y;
            z_reg <= xsr_pkg::SEED_Z;
            w_reg <= xsr_pkg::SEED_W;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            w_reg <= w_next;
        end
    end

    // one quotient bit per step, remainder stays below the span
    assign shifted = {rem_reg, dvd_reg[xsr_pkg::WordW-1]};
    assign trial   = {1'b0, shifted} - {1'b0, span_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg    <= advancing ? new_w : '0;
            dvd_reg    <= new_w;
            rem_reg    <= '0;
            lo_reg     <= req.range_min;
            span_reg   <= span_val;
            status_reg <= status_val;
        end
        else if (cmd.step)
        begin
            dvd_reg <= {dvd_reg[xsr_pkg::WordW-2:0], 1'b0};
            if (!trial[xsr_pkg::WordW+1])
                rem_reg <= trial[xsr_pkg::WordW-1:0];
            else
                rem_reg <= shifted[xsr_pkg::WordW-1:0];
        end
    end

    assign rsp.raw_word     = raw_reg;
    assign rsp.ranged_value = lo_reg + rem_reg;
    assign rsp.range_status = status_reg;

endmodule

// ===== rtl/core/xsr_ctrl.sv =====
// xsr_ctrl: request sequencer; accepts a word, runs the remainder steps, holds the result.
// Depends on xsr_pkg.
module xsr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  xsr_pkg::sts_t sts,
    output xsr_pkg::cmd_t cmd
);

    xsr_pkg::state_t            state_reg, state_next;
    logic [xsr_pkg::CntW-1:0]   cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            xsr_pkg::S_IDLE:
                if (req_valid)
                    state_next = sts.need_div ? xsr_pkg::S_DIV : xsr_pkg::S_OUT;
            xsr_pkg::S_DIV:
                if (cnt_reg == xsr_pkg::DIV_LAST)
                    state_next = xsr_pkg::S_OUT;
            xsr_pkg::S_OUT:
                if (rsp_ready)
                    state_next = xsr_pkg::S_IDLE;
            default:
                state_next = xsr_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        rsp_valid = 1'b0;
        cmd       = '0;
        cnt_next  = '0;
        unique case (state_reg)
            xsr_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            xsr_pkg::S_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            xsr_pkg::S_OUT:
                rsp_valid = 1'b1;
            default:
                cnt_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= xsr_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == xsr_pkg::S_DIV) && (cnt_reg == xsr_pkg::DIV_LAST)
        |=> (state_reg == xsr_pkg::S_OUT))
        else $error("remainder did not finish after last step");
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != xsr_pkg::S_IDLE) |-> !req_ready)
        else $error("request taken while busy");
    a_accept_route: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !sts.need_div |=> rsp_valid)
        else $error("non-ranged word not presented next cycle");
    a_rsp_release: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready |=> (state_reg == xsr_pkg::S_IDLE) && (cnt_reg == '0))
        else $error("sequencer not back to idle after delivery");
`endif

endmodule

// ===== rtl/core/xorshift128_ranged_rng_core.sv =====
// xorshift128_ranged_rng_core: top level of the ranged xorshift128 generator.
// Depends on xsr_pkg, xsr_ctrl and xsr_datapath.
//
// Usage:
//   req channel (req_valid/req_ready/req) takes one request word: opcode
//   raw, ranged or reseed plus inclusive signed bounds range_min/range_max.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one word per
//   request: raw generator word, ranged value and range status.
//   One request is handled at a time; req_ready is high only when idle.
//   Raw, reseed and invalid-range requests present their result in the
//   cycle after acceptance.
//   Ranged requests run a restoring remainder, one quotient bit per cycle,
//   over every bit of the generator word, then present their result.
//   The result stays in its register while rsp_ready is low; no new request
//   is taken until it has been delivered.
//   Reset (rst_n low, asynchronous) loads the fixed seed words and returns
//   the sequencer to idle; no result is pending afterwards.
module xorshift128_ranged_rng_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  xsr_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output xsr_pkg::rsp_t rsp
);

    xsr_pkg::cmd_t cmd;
    xsr_pkg::sts_t sts;

    xsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    xsr_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule
